// ----- hdl/multi_server_priority_dispatch_top_defines.svh -----
// assertion macros for the dispatcher
`ifndef MULTI_SERVER_PRIORITY_DISPATCH_TOP_DEFINES_SVH
`define MULTI_SERVER_PRIORITY_DISPATCH_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MSPD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MSPD_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSPD_ASSERT(label, clk, rst_n, prop, msg)
`define MSPD_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- hdl/mspd_pkg.sv -----
`timescale 1ns / 1ps
package mspd_pkg;
	localparam int TABLE_DEPTH = 16;
	localparam int SERVERS = 8;
	localparam int TW = $clog2(TABLE_DEPTH);
	localparam int SW = $clog2(SERVERS);
	localparam int CW = TW + 1;

	localparam logic [2:0] EV_ACCEPT = 3'd0;
	localparam logic [2:0] EV_REJECT = 3'd1;
	localparam logic [2:0] EV_DISPATCH = 3'd2;
	localparam logic [2:0] EV_DONE = 3'd3;
	localparam logic [2:0] EV_TICK = 3'd4;

	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef struct packed {
		logic req_type;
		logic [15:0] release_time;
		logic [15:0] run_length;
		logic [2:0] job_priority;
	} in_item_t;

	typedef struct packed {
		logic [2:0] event_kind;
		logic [2:0] server_index;
		logic [15:0] job_wait;
		logic [15:0] now_time;
		logic [15:0] worst_wait;
		logic [31:0] wait_sum;
		logic [15:0] done_count;
		logic [4:0] pending_jobs;
		logic last_of_run;
	} out_item_t;

	// job table word: arrival, service, priority, age
	localparam int JW = 16 + 16 + 3 + TW;
	typedef struct packed {
		logic [15:0] arrival;
		logic [15:0] service;
		logic [2:0] prio;
		logic [TW-1:0] age;
	} job_t;
endpackage

// ----- hdl/mspd_ram.sv -----
`timescale 1ns / 1ps
module mspd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- hdl/multi_server_priority_dispatch_top.sv -----
`timescale 1ns / 1ps
`include "multi_server_priority_dispatch_top_defines.svh"
// Priority dispatcher: jobs go into a 16-entry table held in a synchronous RAM
// and are handed to up to 8 servers on each tick. The result of an enqueue item
// is written to the output register as the item is taken. A tick first checks
// every built server for completion (end times held in a small RAM), then
// visits the servers in order; for each free active server it sweeps the table
// for the best arrived job, dispatches it and sweeps again to age the younger
// entries. When a sweep finds no arrived job, the remaining servers are skipped
// and the tick ends with its tick done item.
// Results leave one per cycle through an output register; the sequencer waits
// while it is stalled, and a new item is taken only when the tick has finished
// and the output register is free.
module multi_server_priority_dispatch_top (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [3:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  mspd_pkg::in_item_t in_item,
	output logic out_valid,
	input  logic out_stall,
	output mspd_pkg::out_item_t out_item
);
	localparam int TW = mspd_pkg::TW;
	localparam int SW = mspd_pkg::SW;
	localparam int CW = mspd_pkg::CW;
	localparam int TD = mspd_pkg::TABLE_DEPTH;
	localparam int NS = mspd_pkg::SERVERS;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_ENQ = 4'd1;
	localparam logic [3:0] ST_CRD = 4'd2;
	localparam logic [3:0] ST_CCHK = 4'd3;
	localparam logic [3:0] ST_SRV = 4'd4;
	localparam logic [3:0] ST_SCAN = 4'd5;
	localparam logic [3:0] ST_DISP = 4'd6;
	localparam logic [3:0] ST_AGE = 4'd7;
	localparam logic [3:0] ST_TICK = 4'd8;

	logic [3:0] state_q;
	logic [3:0] cfg_q;
	logic [TD-1:0] valid_q;
	logic [NS-1:0] busy_q;
	logic [15:0] now_q, worst_q, done_q;
	logic [31:0] sum_q;
	logic [CW-1:0] held_q;
	logic [SW:0] srv_q;
	logic [CW-1:0] idx_q;
	logic rd_v_s1;
	logic [TW-1:0] rd_a_s1;
	logic found_q;
	logic [TW-1:0] best_q;
	mspd_pkg::job_t best_job_q;

	// job table ram
	logic jwe;
	logic [TW-1:0] jwa, jra;
	mspd_pkg::job_t jwd, jrd;
	mspd_ram #(.WIDTH(mspd_pkg::JW), .DEPTH(TD)) u_jobs (
		.clk(clk), .we(jwe), .waddr(jwa), .wdata(jwd), .raddr(jra), .rdata(jrd)
	);

	// server end time ram
	logic ewe;
	logic [SW-1:0] ewa, era;
	logic [16:0] ewd, erd;
	mspd_ram #(.WIDTH(17), .DEPTH(NS)) u_ends (
		.clk(clk), .we(ewe), .waddr(ewa), .wdata(ewd), .raddr(era), .rdata(erd)
	);

	// free slot search and active count
	logic [TW-1:0] free_slot;
	logic full;
	always_comb begin
		free_slot = '0;
		full = 1'b1;
		for (int i = TD - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_slot = TW'(i);
				full = 1'b0;
			end
		end
	end
	logic [SW:0] active;
	always_comb begin
		if (cfg_q == 4'd0) active = (SW+1)'(1);
		else if ({1'b0, cfg_q} > 5'(NS)) active = (SW+1)'(NS);
		else active = (SW+1)'(cfg_q);
	end

	logic [15:0] wait_v;
	logic [32:0] sum_add;
	assign wait_v = now_q - best_job_q.arrival;
	assign sum_add = {1'b0, sum_q} + 33'(wait_v);

	logic emit_free;
	assign emit_free = !out_valid || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !emit_free;

	logic scan_hit;
	assign scan_hit = rd_v_s1 && valid_q[rd_a_s1] && jrd.arrival <= now_q &&
		(!found_q || jrd.prio > best_job_q.prio ||
		 (jrd.prio == best_job_q.prio && jrd.age < best_job_q.age));

	always_comb begin
		jwe = 1'b0;
		jwa = free_slot;
		jwd = '0;
		jra = idx_q[TW-1:0];
		ewe = 1'b0;
		ewa = srv_q[SW-1:0];
		ewd = 17'(now_q) + 17'(best_job_q.service);
		era = srv_q[SW-1:0];
		if (state_q == ST_IDLE && in_valid && !in_stall &&
			in_item.req_type == mspd_pkg::REQ_ENQ && !full) begin
			jwe = 1'b1;
			jwd.arrival = in_item.release_time;
			jwd.service = (in_item.run_length == 16'd0) ? 16'd1 : in_item.run_length;
			jwd.prio = in_item.job_priority;
			jwd.age = held_q[TW-1:0];
		end
		if (state_q == ST_DISP && emit_free) ewe = 1'b1;
		if (state_q == ST_AGE && rd_v_s1 && valid_q[rd_a_s1] &&
			jrd.age > best_job_q.age) begin
			jwe = 1'b1;
			jwa = rd_a_s1;
			jwd = jrd;
			jwd.age = jrd.age - TW'(1);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cfg_q <= 4'd1;
			valid_q <= '0;
			busy_q <= '0;
			now_q <= '0;
			worst_q <= '0;
			done_q <= '0;
			sum_q <= '0;
			held_q <= '0;
			out_valid <= 1'b0;
			out_item <= '0;
			srv_q <= '0;
			idx_q <= '0;
			rd_v_s1 <= 1'b0;
			rd_a_s1 <= '0;
			found_q <= 1'b0;
			best_q <= '0;
			best_job_q <= '0;
		end else begin
			if (cfg_we) cfg_q <= cfg_data;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			rd_v_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						if (in_item.req_type == mspd_pkg::REQ_ENQ) begin
							out_valid <= 1'b1;
							out_item <= '{event_kind: full ? mspd_pkg::EV_REJECT
								: mspd_pkg::EV_ACCEPT, server_index: 3'd0, job_wait: 16'd0,
								now_time: now_q, worst_wait: worst_q, wait_sum: sum_q,
								done_count: done_q, pending_jobs: 5'(held_q + CW'(!full)),
								last_of_run: 1'b1};
							if (!full) begin
								valid_q[free_slot] <= 1'b1;
								held_q <= held_q + CW'(1);
							end
						end else begin
							srv_q <= '0;
							state_q <= ST_CRD;
						end
					end
				end
				ST_CRD: begin
					if (srv_q == (SW+1)'(NS)) begin
						srv_q <= '0;
						state_q <= ST_SRV;
					end else state_q <= ST_CCHK;
				end
				ST_CCHK: begin
					if (busy_q[srv_q[SW-1:0]] && erd == 17'(now_q)) begin
						if (emit_free) begin
							busy_q[srv_q[SW-1:0]] <= 1'b0;
							out_valid <= 1'b1;
							out_item <= '{event_kind: mspd_pkg::EV_DONE,
								server_index: 3'(srv_q[SW-1:0]), job_wait: 16'd0,
								now_time: now_q, worst_wait: worst_q, wait_sum: sum_q,
								done_count: (done_q == 16'hFFFF) ? done_q : done_q + 16'd1,
								pending_jobs: 5'(held_q), last_of_run: 1'b0};
							if (done_q != 16'hFFFF) done_q <= done_q + 16'd1;
							srv_q <= srv_q + (SW+1)'(1);
							state_q <= ST_CRD;
						end
					end else begin
						srv_q <= srv_q + (SW+1)'(1);
						state_q <= ST_CRD;
					end
				end
				ST_SRV: begin
					if (srv_q >= active) state_q <= ST_TICK;
					else if (busy_q[srv_q[SW-1:0]]) srv_q <= srv_q + (SW+1)'(1);
					else begin
						idx_q <= '0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q != CW'(TD)) begin
						rd_v_s1 <= 1'b1;
						rd_a_s1 <= idx_q[TW-1:0];
						idx_q <= idx_q + CW'(1);
					end
					if (scan_hit) begin
						found_q <= 1'b1;
						best_q <= rd_a_s1;
						best_job_q <= jrd;
					end
					if (idx_q == CW'(TD) && !rd_v_s1) begin
						state_q <= (found_q) ? ST_DISP : ST_TICK;
					end
				end
				ST_DISP: begin
					if (emit_free) begin
						out_valid <= 1'b1;
						out_item <= '{event_kind: mspd_pkg::EV_DISPATCH,
							server_index: 3'(srv_q[SW-1:0]), job_wait: wait_v,
							now_time: now_q,
							worst_wait: (wait_v >= worst_q) ? wait_v : worst_q,
							wait_sum: sum_add[32] ? 32'hFFFFFFFF : sum_add[31:0],
							done_count: done_q, pending_jobs: 5'(held_q - CW'(1)),
							last_of_run: 1'b0};
						if (wait_v >= worst_q) worst_q <= wait_v;
						sum_q <= sum_add[32] ? 32'hFFFFFFFF : sum_add[31:0];
						busy_q[srv_q[SW-1:0]] <= 1'b1;
						valid_q[best_q] <= 1'b0;
						held_q <= held_q - CW'(1);
						idx_q <= '0;
						state_q <= ST_AGE;
					end
				end
				ST_AGE: begin
					if (idx_q != CW'(TD)) begin
						rd_v_s1 <= 1'b1;
						rd_a_s1 <= idx_q[TW-1:0];
						idx_q <= idx_q + CW'(1);
					end
					if (idx_q == CW'(TD) && !rd_v_s1) begin
						srv_q <= srv_q + (SW+1)'(1);
						state_q <= ST_SRV;
					end
				end
				ST_TICK: begin
					if (emit_free) begin
						out_valid <= 1'b1;
						out_item <= '{event_kind: mspd_pkg::EV_TICK, server_index: 3'd0,
							job_wait: 16'd0,
							now_time: (now_q == 16'hFFFF) ? now_q : now_q + 16'd1,
							worst_wait: worst_q, wait_sum: sum_q, done_count: done_q,
							pending_jobs: 5'(held_q), last_of_run: 1'b1};
						if (now_q != 16'hFFFF) now_q <= now_q + 16'd1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`MSPD_ASSERT(a_held_ok, clk, arst_n, held_q == CW'($countones(valid_q)),
		"held count mismatch")
	`MSPD_ASSERT(a_in_idle, clk, arst_n, (in_valid && !in_stall) |-> state_q == ST_IDLE,
		"item taken while busy")
	`MSPD_ASSERT(a_disp_frees, clk, arst_n,
		(state_q == ST_DISP && emit_free) |=> !valid_q[$past(best_q)],
		"dispatched entry still valid")
endmodule
